// File: sv/edge_walk_span_table_unit_macros.svh
// Assertion macros shared by the span table modules.
// Both expect clk and rst_n in the scope of the module that uses them.
`ifndef EDGE_WALK_SPAN_TABLE_UNIT_MACROS_SVH
`define EDGE_WALK_SPAN_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define EWST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another one on the next clock edge.
`define EWST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define EWST_ASSERT(lbl, prop, msg)
`define EWST_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: sv/ewst_pkg.sv
`default_nettype none
package ewst_pkg;

  // Table and coordinate geometry
  localparam int TABLE_ROWS = 1024;
  localparam int COORD_BITS = 12;
  localparam int ROW_BITS   = $clog2(TABLE_ROWS);
  localparam int BASE_BITS  = 12;
  localparam int QUERY_BITS = 10;
  localparam int CNT_BITS   = 13;
  localparam int CNT_MAX    = (1 << CNT_BITS) - 1;

  // Error term and row difference widths
  localparam int ERR_BITS  = COORD_BITS + 3;
  localparam int DIFF_BITS = ((COORD_BITS > BASE_BITS) ? COORD_BITS : BASE_BITS) + 1;

  // Epoch tags stand in for per-row valid bits
  localparam int EPOCH_BITS = 8;
  localparam int EPOCH_MAX  = (1 << EPOCH_BITS) - 1;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WALK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [QUERY_BITS-1:0]        query_row;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] span_max_x;
    logic signed [COORD_BITS-1:0] span_min_x;
    logic                         row_touched;
    logic                         rows_out_of_range;
    logic [CNT_BITS-1:0]          pixel_count;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [ERR_BITS-1:0]   dx;
    logic signed [ERR_BITS-1:0]   dy;
    logic signed [ERR_BITS-1:0]   err;
    logic                         sx_neg;
    logic                         sy_neg;
    logic [ROW_BITS-1:0]          q_row;
    logic                         q_ok;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/ewst_if.sv
`default_nettype none
// Input channel: one command item per transaction
interface ewst_in_if;
  logic               valid;
  logic               ready;
  ewst_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel: one result item per transaction
interface ewst_out_if;
  logic                valid;
  logic                ready;
  ewst_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ewst_front.sv
`default_nettype none
`include "edge_walk_span_table_unit_macros.svh"
module ewst_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  ewst_in_if.sink           in_ch,
  input  wire logic         init_busy,
  output logic              push_valid,
  input  wire logic         push_ready,
  output ewst_pkg::cmd_t    push_cmd
);

  logic signed [ewst_pkg::ERR_BITS-1:0] ddx;
  logic signed [ewst_pkg::ERR_BITS-1:0] ddy;
  logic signed [ewst_pkg::ERR_BITS-1:0] adx;
  logic signed [ewst_pkg::ERR_BITS-1:0] ady;

  // Take items only when the queue has room and the table is initialized
  assign in_ch.ready = push_ready && !init_busy;
  assign push_valid  = in_ch.valid && !init_busy;

  // Edge deltas and step directions
  assign ddx = ewst_pkg::ERR_BITS'(in_ch.data.end_x) - ewst_pkg::ERR_BITS'(in_ch.data.start_x);
  assign ddy = ewst_pkg::ERR_BITS'(in_ch.data.end_y) - ewst_pkg::ERR_BITS'(in_ch.data.start_y);
  assign adx = ddx[ewst_pkg::ERR_BITS-1] ? -ddx : ddx;
  assign ady = ddy[ewst_pkg::ERR_BITS-1] ? -ddy : ddy;

  // Build the classified command
  always_comb begin
    push_cmd        = '0;
    push_cmd.op     = in_ch.data.operation;
    push_cmd.x0     = in_ch.data.start_x;
    push_cmd.y0     = in_ch.data.start_y;
    push_cmd.x1     = in_ch.data.end_x;
    push_cmd.y1     = in_ch.data.end_y;
    push_cmd.dx     = adx;
    push_cmd.dy     = -ady;
    push_cmd.err    = adx - ady;
    push_cmd.sx_neg = !(in_ch.data.start_x < in_ch.data.end_x);
    push_cmd.sy_neg = !(in_ch.data.start_y < in_ch.data.end_y);
    push_cmd.q_row  = ewst_pkg::ROW_BITS'(in_ch.data.query_row);
    push_cmd.q_ok   = (32'(in_ch.data.query_row) < ewst_pkg::TABLE_ROWS);
  end

  `EWST_ASSERT(a_no_take_in_init, init_busy |-> !in_ch.ready, "item taken during init sweep")

endmodule
`default_nettype wire

// File: sv/ewst_queue.sv
`default_nettype none
module ewst_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ewst_pkg::cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output ewst_pkg::cmd_t       pop_cmd
);

  ewst_pkg::cmd_t slot_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/ewst_back.sv
`default_nettype none
`include "edge_walk_span_table_unit_macros.svh"
module ewst_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [ewst_pkg::BASE_BITS-1:0] base_row,
  input  wire logic                                 pop_valid,
  output logic                                      pop_ready,
  input  wire ewst_pkg::cmd_t                       pop_cmd,
  output logic                                      init_busy,
  ewst_out_if.source                                out_ch
);

  localparam int CB = ewst_pkg::COORD_BITS;
  localparam int EB = ewst_pkg::ERR_BITS;
  localparam int RB = ewst_pkg::ROW_BITS;
  localparam int DB = ewst_pkg::DIFF_BITS;
  localparam int NB = ewst_pkg::CNT_BITS;
  localparam int TB = ewst_pkg::EPOCH_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;

  localparam logic signed [CB-1:0] STEP_UP   = CB'(1);
  localparam logic signed [CB-1:0] STEP_DOWN = -CB'(1);
  localparam logic [TB-1:0]        EPOCH_ONE = TB'(1);
  localparam logic [TB-1:0]        EPOCH_TOP = TB'(ewst_pkg::EPOCH_MAX);
  localparam logic [RB-1:0]        ROW_LAST  = RB'(ewst_pkg::TABLE_ROWS - 1);
  localparam logic [NB-1:0]        CNT_TOP   = NB'(ewst_pkg::CNT_MAX);

  typedef struct packed {
    logic [TB-1:0]        tag;
    logic signed [CB-1:0] max_x;
    logic signed [CB-1:0] min_x;
  } entry_t;

  // Table memory
  entry_t mem [ewst_pkg::TABLE_ROWS];
  entry_t rd_data_r;

  // Control
  logic [2:0]    state_r;
  logic [TB-1:0] epoch_r;
  logic [RB-1:0] sweep_cnt_r;
  logic          sweep_init_r;

  // Walker
  logic signed [CB-1:0] cx_r, cy_r, x1_r, y1_r;
  logic signed [EB-1:0] dx_r, dy_r, err_r;
  logic                 sxn_r, syn_r;
  logic [NB-1:0]        cnt_r;
  logic                 outside_r;

  // Merge stage
  logic          p1_vld_r;
  logic          p1_is_q_r;
  logic [RB-1:0] p1_row_r;
  logic signed [CB-1:0] p1_x_r;

  // Last write, for forwarding
  logic          wr_vld_r;
  logic [RB-1:0] wr_addr_r;
  entry_t        wr_data_r;

  // Result and output slot
  ewst_pkg::out_item_t res_r;
  ewst_pkg::out_item_t out_r;
  logic                out_vld_r;

  // Combinational
  logic signed [DB-1:0] row_diff;
  logic [DB-2:0]        row_u;
  logic                 in_tab;
  logic                 last_px;
  logic signed [EB:0]   e2;
  logic                 step_x, step_y;
  logic signed [EB-1:0] err_nxt;
  logic signed [CB-1:0] cx_nxt, cy_nxt;
  logic [NB-1:0]        cnt_nxt;
  logic                 outside_nxt;
  logic                 do_pop;
  logic                 rd_en;
  logic [RB-1:0]        rd_addr;
  entry_t               ent;
  logic                 ent_ok;
  entry_t               merged;
  logic                 wr_en;
  logic [RB-1:0]        wr_addr;
  entry_t               wr_data;
  logic                 out_load;

  assign pop_ready = (state_r == S_IDLE);
  assign do_pop    = pop_valid && pop_ready;
  assign init_busy = (state_r == S_SWEEP) && sweep_init_r;

  // Map the current pixel to a table row
  assign row_diff = DB'(cy_r) - DB'(base_row);
  assign row_u    = row_diff[DB-2:0];
  assign in_tab   = !row_diff[DB-1] && (32'(row_u) < ewst_pkg::TABLE_ROWS);
  assign last_px  = (cx_r == x1_r) && (cy_r == y1_r);

  // One Bresenham step
  assign e2      = {err_r, 1'b0};
  assign step_x  = (e2 >= dy_r);
  assign step_y  = (e2 <= dx_r);
  assign err_nxt = err_r + (step_x ? dy_r : EB'(0)) + (step_y ? dx_r : EB'(0));
  assign cx_nxt  = step_x ? cx_r + (sxn_r ? STEP_DOWN : STEP_UP) : cx_r;
  assign cy_nxt  = step_y ? cy_r + (syn_r ? STEP_DOWN : STEP_UP) : cy_r;
  assign cnt_nxt = (cnt_r < CNT_TOP) ? cnt_r + NB'(1) : cnt_r;
  assign outside_nxt = outside_r || !in_tab;

  // Read port: pixel lookups while walking, row queries from idle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_u[RB-1:0];
    if (state_r == S_WALK && in_tab) begin
      rd_en = 1'b1;
    end else if (do_pop && pop_cmd.op == ewst_pkg::OP_READ && pop_cmd.q_ok) begin
      rd_en   = 1'b1;
      rd_addr = pop_cmd.q_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Merge the pixel into the row, forwarding the last write
  assign ent    = (wr_vld_r && wr_addr_r == p1_row_r) ? wr_data_r : rd_data_r;
  assign ent_ok = (ent.tag == epoch_r);

  always_comb begin
    merged.tag   = epoch_r;
    merged.max_x = (!ent_ok || p1_x_r > ent.max_x) ? p1_x_r : ent.max_x;
    merged.min_x = (!ent_ok || p1_x_r < ent.min_x) ? p1_x_r : ent.min_x;
  end

  // Write port: merges, or zero tags during a sweep
  always_comb begin
    wr_en   = (p1_vld_r && !p1_is_q_r) || (state_r == S_SWEEP);
    wr_addr = (state_r == S_SWEEP) ? sweep_cnt_r : p1_row_r;
    wr_data = (state_r == S_SWEEP) ? entry_t'('0) : merged;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_load = (state_r == S_FIN) && !p1_vld_r && (!out_vld_r || out_ch.ready);

  // Sequencer, walker and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_init_r <= 1'b1;
      sweep_cnt_r  <= '0;
      epoch_r      <= EPOCH_ONE;
      p1_vld_r     <= 1'b0;
      wr_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_vld_r  <= 1'b1;
        wr_addr_r <= wr_addr;
        wr_data_r <= wr_data;
      end

      // Query answers come out of the merge stage
      if (p1_vld_r && p1_is_q_r) begin
        res_r.span_max_x  <= ent_ok ? ent.max_x : CB'(0);
        res_r.span_min_x  <= ent_ok ? ent.min_x : CB'(0);
        res_r.row_touched <= ent_ok;
      end

      unique case (state_r)
        S_IDLE: begin
          p1_vld_r <= do_pop && pop_cmd.op == ewst_pkg::OP_READ && pop_cmd.q_ok;
          if (do_pop) begin
            res_r     <= '0;
            cx_r      <= pop_cmd.x0;
            cy_r      <= pop_cmd.y0;
            x1_r      <= pop_cmd.x1;
            y1_r      <= pop_cmd.y1;
            dx_r      <= pop_cmd.dx;
            dy_r      <= pop_cmd.dy;
            err_r     <= pop_cmd.err;
            sxn_r     <= pop_cmd.sx_neg;
            syn_r     <= pop_cmd.sy_neg;
            cnt_r     <= '0;
            outside_r <= 1'b0;
            unique case (pop_cmd.op)
              ewst_pkg::OP_CLEAR: begin
                if (epoch_r == EPOCH_TOP) begin
                  state_r     <= S_SWEEP;
                  sweep_cnt_r <= '0;
                end else begin
                  epoch_r <= epoch_r + EPOCH_ONE;
                  state_r <= S_FIN;
                end
              end
              ewst_pkg::OP_WALK: begin
                state_r <= S_WALK;
              end
              ewst_pkg::OP_READ: begin
                p1_is_q_r <= 1'b1;
                p1_row_r  <= pop_cmd.q_row;
                state_r   <= S_FIN;
              end
              ewst_pkg::OP_NOP: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_WALK: begin
          p1_vld_r  <= in_tab;
          p1_is_q_r <= 1'b0;
          p1_row_r  <= row_u[RB-1:0];
          p1_x_r    <= cx_r;
          cnt_r     <= cnt_nxt;
          outside_r <= outside_nxt;
          err_r     <= err_nxt;
          cx_r      <= cx_nxt;
          cy_r      <= cy_nxt;
          if (last_px) begin
            res_r.pixel_count       <= cnt_nxt;
            res_r.rows_out_of_range <= outside_nxt;
            state_r                 <= S_FIN;
          end
        end
        S_FIN: begin
          p1_vld_r <= 1'b0;
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          p1_vld_r    <= 1'b0;
          sweep_cnt_r <= sweep_cnt_r + RB'(1);
          if (sweep_cnt_r == ROW_LAST) begin
            epoch_r      <= EPOCH_ONE;
            sweep_init_r <= 1'b0;
            state_r      <= sweep_init_r ? S_IDLE : S_FIN;
          end
        end
        default: begin
          p1_vld_r <= 1'b0;
          state_r  <= S_IDLE;
        end
      endcase

      // Output slot
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  `EWST_ASSERT(a_merge_in_walk, p1_vld_r |-> (state_r == S_WALK || state_r == S_FIN), "merge outside walk or finish")
  `EWST_ASSERT(a_pop_drained, do_pop |-> !p1_vld_r, "command taken with merge pending")
  `EWST_ASSERT_NEXT(a_fin_hold, state_r == S_FIN && out_vld_r && !out_ch.ready, state_r == S_FIN, "result dropped while stalled")

endmodule
`default_nettype wire

// File: sv/edge_walk_span_table_unit.sv
// Edge walk span table.
// in_ch carries one command per transaction: clear table, walk an edge from
// (start_x, start_y) to (end_x, end_y), or read the span of query_row. Every
// command yields exactly one result on out_ch, in command order.
// cfg_we/cfg_wdata load base_row, the screen y of table row zero; write it
// only while no command is in flight.
// A walk visits one pixel per cycle in the walker. Every 255th clear renews
// the row epoch tags with a sweep of the table memory. Commands run one at
// a time; a two-entry queue behind the input keeps accepting while the back
// end walks.
// After reset the block sweeps the 1024-row table memory with in_ch.ready
// low; base_row resets to zero.
// A stalled receiver holds the result in the output register; the back end
// finishes its next command and then waits, and input stops once the queue
// is full.
`default_nettype none
module edge_walk_span_table_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  ewst_in_if.sink                                   in_ch,
  ewst_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic signed [ewst_pkg::BASE_BITS-1:0] cfg_wdata
);

  logic signed [ewst_pkg::BASE_BITS-1:0] base_row_r;
  logic           init_busy;
  logic           push_valid;
  logic           push_ready;
  ewst_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  ewst_pkg::cmd_t pop_cmd;

  // Hold the base row register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_row_r <= '0;
    end else if (cfg_we) begin
      base_row_r <= cfg_wdata;
    end
  end

  ewst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ewst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ewst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_row  (base_row_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: test/edge_walk_span_table_unit_checker.sv
module edge_walk_span_table_unit_checker
  import ewst_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  ewst_in_if                            in_mon,
  ewst_out_if                           out_mon,
  input  logic                          cfg_we,
  input  logic signed [BASE_BITS-1:0]   cfg_wdata,
  output int                            mismatches,
  output int                            results_owed,
  output int                            results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the span table and the base row register
  logic signed [COORD_BITS-1:0] span_hi [TABLE_ROWS];
  logic signed [COORD_BITS-1:0] span_lo [TABLE_ROWS];
  bit                           row_live [TABLE_ROWS];
  int                           base_row_q;
  out_item_t                    span_results_due [$];

  // Apply one command to the shadow table and return the result it must produce
  function automatic out_item_t predict_span(in_item_t cmd);
    out_item_t r;
    int x, y, x1, y1, dx, dy, sx, sy, err, e2, row, n;
    bit off, done;
    r = '0;
    case (cmd.operation)
      OP_CLEAR: begin
        foreach (row_live[i]) row_live[i] = 1'b0;
      end
      OP_WALK: begin
        x  = int'(cmd.start_x);
        y  = int'(cmd.start_y);
        x1 = int'(cmd.end_x);
        y1 = int'(cmd.end_y);
        dx = (x1 > x) ? x1 - x : x - x1;
        dy = (y1 > y) ? y - y1 : y1 - y;
        sx = (x < x1) ? 1 : -1;
        sy = (y < y1) ? 1 : -1;
        err = dx + dy;
        n = 0;
        off = 1'b0;
        done = 1'b0;
        while (!done) begin
          // Widen the row span, or flag a pixel that falls outside the table
          row = y - base_row_q;
          if (row < 0 || row >= TABLE_ROWS) begin
            off = 1'b1;
          end else if (!row_live[row]) begin
            row_live[row] = 1'b1;
            span_hi[row] = COORD_BITS'(x);
            span_lo[row] = COORD_BITS'(x);
          end else begin
            if (x > span_hi[row]) span_hi[row] = COORD_BITS'(x);
            if (x < span_lo[row]) span_lo[row] = COORD_BITS'(x);
          end
          if (n < CNT_MAX) n++;
          if (x == x1 && y == y1) begin
            done = 1'b1;
          end else begin
            // Advance along the edge with the integer error term
            e2 = err * 2;
            if (e2 >= dy) begin
              err += dy;
              x += sx;
            end
            if (e2 <= dx) begin
              err += dx;
              y += sy;
            end
          end
        end
        r.rows_out_of_range = off;
        r.pixel_count = n[CNT_BITS-1:0];
      end
      OP_READ: begin
        if (int'(cmd.query_row) < TABLE_ROWS && row_live[cmd.query_row]) begin
          r.span_max_x  = span_hi[cmd.query_row];
          r.span_min_x  = span_lo[cmd.query_row];
          r.row_touched = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit field_ok(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  // Track configuration, check results against the oldest prediction, queue new ones
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    bit ok;
    if (!rst_n) begin
      foreach (row_live[i]) begin
        row_live[i] = 1'b0;
        span_hi[i] = '0;
        span_lo[i] = '0;
      end
      base_row_q = 0;
      span_results_due.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (cfg_we) base_row_q = int'(cfg_wdata);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (span_results_due.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %p",
                   $time, got);
          mismatches++;
        end else begin
          want = span_results_due.pop_front();
          ok = 1'b1;
          ok &= field_ok("span_max_x", 32'(want.span_max_x), 32'(got.span_max_x));
          ok &= field_ok("span_min_x", 32'(want.span_min_x), 32'(got.span_min_x));
          ok &= field_ok("row_touched", 32'(want.row_touched), 32'(got.row_touched));
          ok &= field_ok("rows_out_of_range", 32'(want.rows_out_of_range),
                         32'(got.rows_out_of_range));
          ok &= field_ok("pixel_count", 32'(want.pixel_count), 32'(got.pixel_count));
          if (!ok) mismatches++;
          results_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        span_results_due.push_back(predict_span(in_mon.data));
    end
    results_owed = span_results_due.size();
  end

endmodule

// File: test/edge_walk_span_table_unit_test.sv
module edge_walk_span_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ewst_pkg::*;

  localparam int TOTAL_ITEMS    = 1150;
  localparam int PHASE_ITEMS    = 150;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 16;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic signed [BASE_BITS-1:0] cfg_wdata;
  int                          mismatches;
  int                          results_owed;
  int                          results_checked;

  // Stimulus bookkeeping
  int base_now;
  int burst_left;
  int n_sent, n_walk, n_read, n_clear, n_nop, n_bases;
  bit no_gaps;
  bit hold_req, hold_active, hold_done;

  ewst_in_if  in_ch ();
  ewst_out_if out_ch ();

  edge_walk_span_table_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  edge_walk_span_table_unit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic in_item_t mk(logic [1:0] op, int x0, int y0, int x1, int y1, int q);
    in_item_t it;
    it.operation = op;
    it.start_x   = COORD_BITS'(x0);
    it.start_y   = COORD_BITS'(y0);
    it.end_x     = COORD_BITS'(x1);
    it.end_y     = COORD_BITS'(y1);
    it.query_row = QUERY_BITS'(q);
    return it;
  endfunction

  // Offer one transaction in bursts with random gaps; return once it is accepted
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || hold_active || $urandom_range(3) == 0) ? 0 : rnd(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = rnd(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_sent++;
    case (it.operation)
      OP_CLEAR: n_clear++;
      OP_WALK:  n_walk++;
      OP_READ:  n_read++;
      default:  n_nop++;
    endcase
  endtask

  task automatic walk(int x0, int y0, int x1, int y1);
    send(mk(OP_WALK, x0, y0, x1, y1, int'($urandom_range(1023))));
  endtask

  task automatic read_row(int q);
    send(mk(OP_READ, rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047),
            rnd(-2048, 2047), q));
  endtask

  task automatic clear_table();
    send(mk(OP_CLEAR, rnd(-2048, 2047), rnd(-2048, 2047), rnd(-2048, 2047),
            rnd(-2048, 2047), int'($urandom_range(1023))));
  endtask

  // Drain the block, then load a new base row
  task automatic set_base(int v);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= BASE_BITS'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    base_now = v;
    burst_left = 0;
    n_bases++;
  endtask

  // Walk the edges of a random triangle near the table, then read rows it covers
  task automatic triangle_run();
    int cx, cy, r, edges, ylo, yhi, y, q;
    int vx [3];
    int vy [3];
    cy = clamp_coord(base_now + rnd(-12, 1035));
    cx = rnd(-2048, 2047);
    r  = ($urandom_range(9) == 0) ? rnd(40, 300) : rnd(0, 40);
    for (int i = 0; i < 3; i++) begin
      vx[i] = clamp_coord(cx + rnd(-r, r));
      vy[i] = clamp_coord(cy + rnd(-r, r));
    end
    // Now and then leave the outline unfinished
    edges = ($urandom_range(7) == 0) ? rnd(1, 2) : 3;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(1))
        walk(vx[i], vy[i], vx[(i + 1) % 3], vy[(i + 1) % 3]);
      else
        walk(vx[(i + 1) % 3], vy[(i + 1) % 3], vx[i], vy[i]);
    end
    ylo = vy[0];
    yhi = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vy[i] < ylo) ylo = vy[i];
      if (vy[i] > yhi) yhi = vy[i];
    end
    repeat (rnd(1, 4)) begin
      y = rnd(ylo, yhi);
      q = y - base_now;
      if (q < 0 || q >= TABLE_ROWS) q = int'($urandom_range(1023));
      read_row(q);
    end
  endtask

  // Any operation with loosely shaped fields
  task automatic noise_item();
    logic [1:0] op;
    int x0, y0, x1, y1, span;
    op = 2'($urandom_range(3));
    x0 = rnd(-2048, 2047);
    y0 = $urandom_range(1) ? clamp_coord(base_now + rnd(-20, 1043)) : rnd(-2048, 2047);
    span = ($urandom_range(39) == 0) ? 4095 : rnd(0, 60);
    x1 = clamp_coord(x0 + rnd(-span, span));
    y1 = clamp_coord(y0 + rnd(-span, span));
    send(mk(op, x0, y0, x1, y1, int'($urandom_range(1023))));
  endtask

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results still owed",
             $time, WATCHDOG_LIMIT, results_owed);
    $display("TB_ERROR");
    $finish;
  end

  // Result receiver: stall in segments of varying density, plus one long hold-off
  initial begin : receiver
    int seg, pct;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_active = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
        hold_active = 1'b0;
        hold_done = 1'b1;
      end else begin
        seg = rnd(4, 64);
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 85;
        endcase
        repeat (seg) begin
          @(negedge clk);
          out_ch.ready <= ($urandom_range(99) >= pct);
        end
      end
    end
  end

  initial begin : stimulus
    int phase, phase_start, pick;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    set_base(0);

    // Directed: untouched rows, no-op, single pixel, full-width and full-height edges
    read_row(5);
    send(mk(OP_NOP, -1, -1, -1, -1, 1023));
    walk(10, 5, 10, 5);
    read_row(5);
    walk(-2048, 5, 2047, 5);
    read_row(5);
    walk(7, -2048, 7, 2047);
    read_row(0);
    read_row(1023);
    // Steep and shallow edges in negative directions
    walk(100, 300, 40, 200);
    walk(0, 0, -50, 13);
    read_row(300);
    read_row(250);
    read_row(6);
    // Clear, then edges that leave the table below and above
    clear_table();
    read_row(5);
    read_row(300);
    walk(30, -100, -30, -10);
    walk(-2048, 1023, -2000, 1000);
    read_row(1023);
    walk(2047, 1024, 2040, 1030);
    read_row(1000);
    send(mk(OP_NOP, 0, 0, 0, 0, 0));

    // Random phases, each under its own base row
    phase = 0;
    while (n_sent < TOTAL_ITEMS) begin
      case (phase)
        0:       set_base(-2048);
        1:       set_base(2047);
        2:       set_base(0);
        default: set_base(rnd(-2048, 1500));
      endcase
      no_gaps = (phase % 3 == 2);
      phase_start = n_sent;
      while (n_sent < phase_start + PHASE_ITEMS && n_sent < TOTAL_ITEMS) begin
        if (phase == 2 && !hold_req && n_sent > phase_start + 30) hold_req = 1'b1;
        pick = $urandom_range(9);
        if (pick == 0)
          clear_table();
        else if (pick < 8)
          triangle_run();
        else
          repeat (rnd(1, 4)) noise_item();
      end
      phase++;
    end

    // Drain and settle
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d edge walks, %0d row reads, %0d clears, %0d no-ops over %0d base rows",
             n_walk, n_read, n_clear, n_nop, n_bases);
    $display("%0d results compared; long receiver hold-off %s",
             results_checked, hold_done ? "done" : "not reached");
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
